// ===== rtl/core/baro_temp_pressure_compensation_defines.svh =====
// Assertion macros for the barometric compensation block.
// Uses the aclk and aresetn names of the including module.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
`define BTPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BTPC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BTPC_ASSERT(lbl, prop, msg)
`define BTPC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/btpc_pkg.sv =====
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies.
package btpc_pkg;

    localparam int DIV_W = 32;
    localparam int SIDE_W = 20;
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int DIV100_SHIFT = 37;
    localparam logic [25:0] PRESS_MAX = 26'd42949672;

    typedef enum logic [1:0] {
        CFG_TEMP_CAL   = 2'd0,
        CFG_PRESS_A    = 2'd1,
        CFG_PRESS_B    = 2'd2,
        CFG_PRESS_NINE = 2'd3
    } cfg_index_t;

    // coefficients widened to 32 bits
    typedef struct packed {
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] p3;
        logic signed [31:0] p4;
        logic signed [31:0] p5;
        logic signed [31:0] p6;
        logic signed [31:0] p7;
        logic signed [31:0] p8;
        logic signed [31:0] p9;
    } cal_t;

    // travels beside the divider
    typedef struct packed {
        logic [17:0] tdeg;
        logic        post_dbl;
        logic        zero_den;
    } side_t;

    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic signed [31:0] ux16(input logic [15:0] v);
        ux16 = {16'b0, v};
    endfunction

endpackage

// ===== rtl/core/btpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on btpc_pkg.
module btpc_div #(
    parameter int W = btpc_pkg::DIV_W,
    parameter int SW = btpc_pkg::SIDE_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [W-1:0]  quot,
    output logic [SW-1:0] side_out
);
    import btpc_pkg::*;

    logic          valid_reg [0:W];
    logic [W-1:0]  rem_reg   [0:W];
    logic [W-1:0]  num_reg   [0:W];
    logic [W-1:0]  quot_reg  [0:W];
    logic [W-1:0]  den_reg   [0:W];
    logic [SW-1:0] side_reg  [0:W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= '0;
            num_reg[0]  <= num;
            quot_reg[0] <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;
        assign trial = {rem_reg[i], num_reg[i][W-1]};
        assign diff  = trial - {1'b0, den_reg[i]};
        assign ge    = trial >= {1'b0, den_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (adv) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
                num_reg[i+1]  <= {num_reg[i][W-2:0], 1'b0};
                quot_reg[i+1] <= {quot_reg[i][W-2:0], ge};
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign quot      = quot_reg[W];
    assign side_out  = side_reg[W];

endmodule

// ===== rtl/core/btpc_front.sv =====
// Temperature compensation and pressure divisor/dividend, nine stages.
// Depends on btpc_pkg.
module btpc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [7:0]            pressure_msb,
    input  logic [7:0]            pressure_lsb,
    input  logic [7:0]            pressure_xlsb,
    input  logic [7:0]            temp_msb,
    input  logic [7:0]            temp_lsb,
    input  logic [7:0]            temp_xlsb,
    input  btpc_pkg::cal_t        cal,
    output logic                  out_valid,
    output logic [31:0]           num,
    output logic [31:0]           den,
    output btpc_pkg::side_t       side
);
    import btpc_pkg::*;

    logic [8:0] valid_reg;

    logic [19:0] praw, traw;
    assign praw = {pressure_msb, pressure_lsb, pressure_xlsb[7:4]};
    assign traw = {temp_msb, temp_lsb, temp_xlsb[7:4]};

    logic signed [31:0] x1_reg, d_reg;
    logic signed [31:0] ma_reg, dd_reg;
    logic signed [31:0] a_reg, mb_reg;
    logic signed [31:0] tfine_reg;
    logic signed [31:0] tc_reg, qq_reg, m5_reg, m2_reg;
    logic signed [31:0] m6_reg, m3_reg, m5b_reg, m2b_reg;
    logic [31:0]        tabs_reg;
    logic signed [31:0] v2_reg, v1b_reg;
    logic [63:0]        tprod_reg;
    logic signed [31:0] m1_reg, pre_reg;
    logic [17:0]        tdeg8_reg;
    logic signed [31:0] den_reg, pm_reg;
    logic [17:0]        tdeg9_reg;
    logic [19:0]        praw_reg [1:7];
    logic               tneg_reg [6:7];

    logic signed [31:0] v1_c, q_c, tfine5_c;
    logic [26:0]        tq_c;
    assign v1_c     = (tfine_reg >>> 1) - 32'sd64000;
    assign q_c      = v1_c >>> 2;
    assign tfine5_c = 32'(tfine_reg * 32'sd5) + 32'sd128;
    assign tq_c     = tprod_reg[63:DIV100_SHIFT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg      <= 32'({12'b0, traw} >> 3) - (cal.t1 <<< 1);
            d_reg       <= 32'({12'b0, traw} >> 4) - cal.t1;
            praw_reg[1] <= praw;

            ma_reg      <= 32'(x1_reg * cal.t2);
            dd_reg      <= 32'(d_reg * d_reg);
            praw_reg[2] <= praw_reg[1];

            a_reg       <= ma_reg >>> 11;
            mb_reg      <= 32'((dd_reg >>> 12) * cal.t3);
            praw_reg[3] <= praw_reg[2];

            tfine_reg   <= a_reg + (mb_reg >>> 14);
            praw_reg[4] <= praw_reg[3];

            tc_reg      <= tfine5_c >>> 8;
            qq_reg      <= 32'(q_c * q_c);
            m5_reg      <= 32'(v1_c * cal.p5);
            m2_reg      <= 32'(cal.p2 * v1_c);
            praw_reg[5] <= praw_reg[4];

            m6_reg      <= 32'((qq_reg >>> 11) * cal.p6);
            m3_reg      <= 32'(cal.p3 * (qq_reg >>> 13));
            m5b_reg     <= m5_reg;
            m2b_reg     <= m2_reg;
            tneg_reg[6] <= tc_reg[31];
            tabs_reg    <= tc_reg[31] ? 32'(-tc_reg) : tc_reg;
            praw_reg[6] <= praw_reg[5];

            v2_reg      <= ((m6_reg + (m5b_reg <<< 1)) >>> 2) + (cal.p4 <<< 16);
            v1b_reg     <= ((m3_reg >>> 3) + (m2b_reg >>> 1)) >>> 18;
            tprod_reg   <= 64'(tabs_reg) * 64'(DIV100_MAGIC);
            tneg_reg[7] <= tneg_reg[6];
            praw_reg[7] <= praw_reg[6];

            m1_reg      <= 32'((32'sd32768 + v1b_reg) * cal.p1);
            pre_reg     <= (32'sd1048576 - $signed({12'b0, praw_reg[7]})) - (v2_reg >>> 12);
            tdeg8_reg   <= tneg_reg[7] ? 18'(-tq_c) : tq_c[17:0];

            den_reg     <= m1_reg >>> 15;
            pm_reg      <= 32'(pre_reg * 32'sd3125);
            tdeg9_reg   <= tdeg8_reg;
        end
    end

    // large dividend: halve the doubling, double the quotient afterwards
    assign out_valid     = valid_reg[8];
    assign num           = pm_reg[31] ? pm_reg : {pm_reg[30:0], 1'b0};
    assign den           = den_reg;
    assign side.tdeg     = tdeg9_reg;
    assign side.post_dbl = pm_reg[31];
    assign side.zero_den = den_reg == 32'sd0;

endmodule

// ===== rtl/core/btpc_back.sv =====
// Pressure fine correction after the divide, then scaling to hPa.
// Depends on btpc_pkg.
module btpc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [31:0]     quot,
    input  btpc_pkg::side_t side,
    input  btpc_pkg::cal_t  cal,
    output logic            out_valid,
    output logic [17:0]     temperature_deg,
    output logic [25:0]     pressure_hpa
);
    import btpc_pkg::*;

    logic [4:0] valid_reg;

    logic [31:0]        p_c, ps_c;
    assign p_c  = side.post_dbl ? {quot[30:0], 1'b0} : quot;
    assign ps_c = p_c >> 3;

    logic [31:0]        p1_reg, sq_reg;
    logic [31:0]        p2_reg;
    logic signed [31:0] e1m_reg, e2m_reg;
    logic [31:0]        pf_reg;
    logic [63:0]        pprod_reg;
    logic [25:0]        press_reg;
    logic [17:0]        tdeg_reg [1:5];
    logic               zero_reg [1:2];

    logic signed [31:0] e_c;
    assign e_c = (e1m_reg >>> 12) + (e2m_reg >>> 13) + cal.p7;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg      <= p_c;
            sq_reg      <= 32'(ps_c * ps_c);
            zero_reg[1] <= side.zero_den;
            tdeg_reg[1] <= side.tdeg;

            p2_reg      <= p1_reg;
            e1m_reg     <= $signed(32'(cal.p9 * $signed(sq_reg >> 13)));
            e2m_reg     <= $signed(32'($signed(p1_reg >> 2) * cal.p8));
            zero_reg[2] <= zero_reg[1];
            tdeg_reg[2] <= tdeg_reg[1];

            pf_reg      <= zero_reg[2] ? 32'd0 : p2_reg + 32'(e_c >>> 4);
            tdeg_reg[3] <= tdeg_reg[2];

            pprod_reg   <= 64'(pf_reg) * 64'(DIV100_MAGIC);
            tdeg_reg[4] <= tdeg_reg[3];

            press_reg   <= pprod_reg[DIV100_SHIFT+25:DIV100_SHIFT];
            tdeg_reg[5] <= tdeg_reg[4];
        end
    end

    assign out_valid       = valid_reg[4];
    assign temperature_deg = tdeg_reg[5];
    assign pressure_hpa    = press_reg;

endmodule

// ===== rtl/core/baro_temp_pressure_compensation.sv =====
// Top level: config registers, front stages, divider, back stages.
// Depends on btpc_pkg, btpc_front, btpc_div, btpc_back and the defines header.
//
//  channel | ports                         | direction
//  s_      | s_valid/s_ready + 6 bytes     | in, raw sensor word
//  m_      | m_valid/m_ready + 2 fields    | out, compensated word
//  cfg_    | cfg_valid/cfg_ready, idx,data | in, calibration write
//
// One word per cycle while no stall at m_ holds it; 9 front, 33 divider and 5 back stages,
// the divider the longest part, with one bit per stage. Reset clears all valid bits and the
// calibration registers. A stall at m_ freezes every stage at once; s_ready
// is low only while the output word waits.
`include "baro_temp_pressure_compensation_defines.svh"
module baro_temp_pressure_compensation (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_pressure_msb,
    input  logic [7:0]                 s_pressure_lsb,
    input  logic [7:0]                 s_pressure_xlsb,
    input  logic [7:0]                 s_temp_msb,
    input  logic [7:0]                 s_temp_lsb,
    input  logic [7:0]                 s_temp_xlsb,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [17:0]         m_temperature_deg,
    output logic [25:0]                m_pressure_hpa,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  btpc_pkg::cfg_index_t       cfg_index,
    input  logic [63:0]                cfg_data
);
    import btpc_pkg::*;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_cal_a_reg;
    logic [63:0] press_cal_b_reg;
    logic [15:0] press_cal_nine_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg       <= '0;
            press_cal_a_reg    <= '0;
            press_cal_b_reg    <= '0;
            press_cal_nine_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TEMP_CAL:   temp_cal_reg       <= cfg_data[47:0];
                CFG_PRESS_A:    press_cal_a_reg    <= cfg_data;
                CFG_PRESS_B:    press_cal_b_reg    <= cfg_data;
                CFG_PRESS_NINE: press_cal_nine_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    cal_t cal;
    assign cal.t1 = ux16(temp_cal_reg[15:0]);
    assign cal.t2 = sx16(temp_cal_reg[31:16]);
    assign cal.t3 = sx16(temp_cal_reg[47:32]);
    assign cal.p1 = ux16(press_cal_a_reg[15:0]);
    assign cal.p2 = sx16(press_cal_a_reg[31:16]);
    assign cal.p3 = sx16(press_cal_a_reg[47:32]);
    assign cal.p4 = sx16(press_cal_a_reg[63:48]);
    assign cal.p5 = sx16(press_cal_b_reg[15:0]);
    assign cal.p6 = sx16(press_cal_b_reg[31:16]);
    assign cal.p7 = sx16(press_cal_b_reg[47:32]);
    assign cal.p8 = sx16(press_cal_b_reg[63:48]);
    assign cal.p9 = sx16(press_cal_nine_reg);

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic             front_valid;
    logic [DIV_W-1:0] num, den;
    side_t            front_side;

    btpc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (s_valid),
        .pressure_msb  (s_pressure_msb),
        .pressure_lsb  (s_pressure_lsb),
        .pressure_xlsb (s_pressure_xlsb),
        .temp_msb      (s_temp_msb),
        .temp_lsb      (s_temp_lsb),
        .temp_xlsb     (s_temp_xlsb),
        .cal           (cal),
        .out_valid     (front_valid),
        .num           (num),
        .den           (den),
        .side          (front_side)
    );

    logic             div_valid;
    logic [DIV_W-1:0] quot;
    side_t            div_side;

    btpc_div #(
        .W  (DIV_W),
        .SW ($bits(side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid),
        .num       (num),
        .den       (den),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quot      (quot),
        .side_out  (div_side)
    );

    logic [17:0] tdeg;

    btpc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (div_valid),
        .quot            (quot),
        .side            (div_side),
        .cal             (cal),
        .out_valid       (m_valid),
        .temperature_deg (tdeg),
        .pressure_hpa    (m_pressure_hpa)
    );

    assign m_temperature_deg = $signed(tdeg);

    `BTPC_ASSERT(a_ready_follows_out, s_ready == (!m_valid || m_ready), "s_ready mismatch")
    `BTPC_ASSERT(a_press_range, m_valid |-> m_pressure_hpa <= PRESS_MAX, "hPa out of range")
    `BTPC_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "m_valid after reset")

endmodule

// ===== verif/tb.sv =====
// Testbench for baro_temp_pressure_compensation: random and directed sensor words,
// checked against an in-bench model of the 32-bit integer compensation.
// Depends on btpc_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb;
    import btpc_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_pressure_msb = '0, s_pressure_lsb = '0, s_pressure_xlsb = '0;
    logic [7:0] s_temp_msb = '0, s_temp_lsb = '0, s_temp_xlsb = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [17:0] m_temperature_deg;
    logic [25:0] m_pressure_hpa;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = CFG_TEMP_CAL;
    logic [63:0] cfg_data = '0;

    baro_temp_pressure_compensation uut (.*);

    typedef struct packed {
        logic [17:0] tdeg;
        logic [25:0] phpa;
    } comp_word_t;

    logic [47:0] temp_cal_q;
    logic [63:0] press_a_q, press_b_q;
    logic [15:0] press_nine_q;
    comp_word_t expected_q[$];
    int n_mismatch = 0;
    int hold_cnt = 0;
    bit stall_out = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] sar(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] s16(input logic [63:0] w, input int lsb);
        logic [15:0] v;
        v = w[lsb +: 16];
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_word_t compensate(input logic [7:0] pm, pl, px, tm, tl, tx);
        logic [31:0] praw, traw, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, d, b, tfine, tc, v1, q, qq, v2, p, ps, e1, e2;
        logic signed [31:0] tdeg;
        comp_word_t r;
        praw = {12'd0, pm, pl, px[7:4]};
        traw = {12'd0, tm, tl, tx[7:4]};
        t1 = {16'd0, temp_cal_q[15:0]};
        t2 = s16({16'd0, temp_cal_q}, 16); t3 = s16({16'd0, temp_cal_q}, 32);
        p1 = {16'd0, press_a_q[15:0]};
        p2 = s16(press_a_q, 16); p3 = s16(press_a_q, 32); p4 = s16(press_a_q, 48);
        p5 = s16(press_b_q, 0); p6 = s16(press_b_q, 16);
        p7 = s16(press_b_q, 32); p8 = s16(press_b_q, 48);
        p9 = {{16{press_nine_q[15]}}, press_nine_q};
        a = sar(((traw >> 3) - (t1 << 1)) * t2, 11);
        d = (traw >> 4) - t1;
        b = sar(sar(d * d, 12) * t3, 14);
        tfine = a + b;
        tc = sar(tfine * 32'd5 + 32'd128, 8);
        tdeg = $signed(tc) / 32'sd100;
        v1 = sar(tfine, 1) - 32'd64000;
        q = sar(v1, 2);
        qq = q * q;
        v2 = sar(qq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sar(v2, 2) + (p4 << 16);
        v1 = sar(sar(p3 * sar(qq, 13), 3) + sar(p2 * v1, 1), 18);
        v1 = sar((32'd32768 + v1) * p1, 15);
        p = 32'd0;
        if (v1 != 0) begin
            p = ((32'd1048576 - praw) - sar(v2, 12)) * 32'd3125;
            if (p < 32'h80000000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            ps = p >> 3;
            e1 = sar(p9 * ((ps * ps) >> 13), 12);
            e2 = sar((p >> 2) * p8, 13);
            p = p + sar(e1 + e2 + p7, 4);
        end
        r.tdeg = tdeg[17:0];
        r.phpa = 26'(p / 32'd100);
        return r;
    endfunction

    // drops valid only when a gap really follows
    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return;
        s_valid <= 1'b0;
        repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(5, 40)) @(posedge aclk);
    endtask

    task automatic send_word(input logic [7:0] pm, pl, px, tm, tl, tx, input bit gaps);
        if (gaps) idle_gap();
        s_valid <= 1'b1;
        s_pressure_msb <= pm; s_pressure_lsb <= pl; s_pressure_xlsb <= px;
        s_temp_msb <= tm; s_temp_lsb <= tl; s_temp_xlsb <= tx;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(compensate(pm, pl, px, tm, tl, tx));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_cal(input cfg_index_t idx, input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TEMP_CAL: temp_cal_q = v[47:0];
            CFG_PRESS_A: press_a_q = v;
            CFG_PRESS_B: press_b_q = v;
            CFG_PRESS_NINE: press_nine_q = v[15:0];
        endcase
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] pa, pb,
                            input logic [15:0] p9);
        drain();
        write_cal(CFG_TEMP_CAL, {16'd0, tc});
        write_cal(CFG_PRESS_A, pa);
        write_cal(CFG_PRESS_B, pb);
        write_cal(CFG_PRESS_NINE, {48'd0, p9});
        cfg_valid <= 1'b0;
    endtask

    // typical datasheet-like coefficients
    task automatic load_typical();
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd208, 16'hD4BC, 16'd36477},
                 {16'd15500, 16'hC1F4, 16'hFFF9, 16'd140}, 16'd6000);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rbyte();
        return 8'($urandom);
    endfunction

    task automatic test_zero_divisor();
        // registers at reset: P1 zero, so pressure is forced to zero
        send_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        load_cal(48'(rand64()), {48'(rand64() >> 16), 16'd0}, rand64(), 16'($urandom));
        send_word(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00, 0);
    endtask

    task automatic test_directed_extremes();
        load_typical();
        send_word(8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00, 0);
        send_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        send_word(8'hFF, 8'h00, 8'h0F, 8'h00, 8'hFF, 8'hF0, 0);
        send_word(8'h80, 8'h80, 8'h8F, 8'h80, 8'h80, 8'h8F, 0);
        load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        send_word(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 0);
        send_word(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00, 0);
        load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                 {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        send_word(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 0);
        send_word(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00, 0);
        send_word(8'h55, 8'hAA, 8'h5A, 8'hAA, 8'h55, 8'hA5, 0);
    endtask

    task automatic test_random_cal(input int n_words);
        for (int i = 0; i < n_words; i++) begin
            if (i % 100 == 0) begin
                if ($urandom_range(0, 2) == 0) load_typical();
                else load_cal(48'(rand64()), rand64(), rand64(), 16'($urandom));
            end
            send_word(rbyte(), rbyte(), rbyte(), rbyte(), rbyte(), rbyte(), 1);
        end
    endtask

    task automatic test_back_to_back(input int n_words);
        stall_out = 1'b0;
        for (int i = 0; i < n_words; i++)
            send_word(rbyte(), rbyte(), rbyte(), rbyte(), rbyte(), rbyte(), 0);
        drain();
        stall_out = 1'b1;
    endtask

    // result side: random backpressure and the compare
    always @(posedge aclk) begin
        comp_word_t e;
        int r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected word t=%0d p=%0d",
                                               m_temperature_deg, m_pressure_hpa);
            end else begin
                e = expected_q.pop_front();
                if (m_temperature_deg !== e.tdeg || m_pressure_hpa !== e.phpa) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp t=%0d p=%0d got t=%0d p=%0d",
                                 $signed(e.tdeg), e.phpa, m_temperature_deg, m_pressure_hpa);
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!stall_out) begin
            m_ready <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            // mostly short stalls, now and then a long one
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                hold_cnt = (r < 97) ? $urandom_range(0, 2) : $urandom_range(4, 39);
            end
        end
    end

    initial begin
        stall_out = 1'b1;
        temp_cal_q = '0; press_a_q = '0; press_b_q = '0; press_nine_q = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_divisor();
        test_directed_extremes();
        test_back_to_back(100);
        test_random_cal(920);
        drain();
        if (n_mismatch == 0 && expected_q.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
